// File: design/jtl_pkg.sv
// Package: shared types, character codes and byte classes for the JSON token lexer.
`default_nettype none

package jtl_pkg;

    // Default saturation limit for byte offsets
    localparam int unsigned LEN_MAX_DEF = 65536;

    // Results one byte can cause, and the result queue that holds them
    localparam int unsigned MAX_RES   = 3;
    localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);
    localparam int unsigned RQ_DEPTH  = 4;
    localparam int unsigned RQ_IDX_W  = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;

    typedef enum logic [3:0] {
        KIND_LBRACE  = 4'd0,
        KIND_RBRACE  = 4'd1,
        KIND_LBRACK  = 4'd2,
        KIND_RBRACK  = 4'd3,
        KIND_COMMA   = 4'd4,
        KIND_COLON   = 4'd5,
        KIND_DOT     = 4'd6,
        KIND_STRING  = 4'd7,
        KIND_NUMBER  = 4'd8,
        KIND_KEYWORD = 4'd9,
        KIND_EOF     = 4'd10,
        KIND_ERROR   = 4'd11
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BYTE     = 2'd1,
        ERR_UNCLOSED = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        LM_IDLE = 3'd0,
        LM_STR  = 3'd1,
        LM_ESC  = 3'd2,
        LM_NUM  = 3'd3,
        LM_KEY  = 3'd4,
        LM_HALT = 3'd5
    } t_lex_mode;

    // Everything of a result but its offsets
    typedef struct packed {
        t_kind kind;
        t_err  ek;
        logic  last;
    } t_res_tag;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return c inside {[CH_LC_A:CH_LC_Z]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                         CH_COMMA, CH_COLON, CH_DOT};
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_COMMA:  k = KIND_COMMA;
            CH_COLON:  k = KIND_COLON;
            CH_DOT:    k = KIND_DOT;
            default:   k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: design/jtl_lexer.sv
// Lexer state registers and the per-byte step that yields up to three results.
`default_nettype none

module jtl_lexer
    import jtl_pkg::*;
#(
    parameter int unsigned MAX_LEN = LEN_MAX_DEF,
    parameter int unsigned POS_W   = $clog2(MAX_LEN + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_last,
    output logic [RES_CNT_W-1:0]      o_cnt,
    output t_res_tag                  o_tag   [MAX_RES],
    output logic [POS_W-1:0]          o_start [MAX_RES],
    output logic [POS_W-1:0]          o_end   [MAX_RES]
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);
    localparam int unsigned      NCAND   = 6;

    t_lex_mode        r_mode, n_mode, mid_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_begin, n_begin, mid_begin;
    logic [POS_W-1:0] nxt;
    logic             tok_ends;
    logic             idle_go;

    logic             cv  [NCAND];
    t_kind            ck  [NCAND];
    t_err             cek [NCAND];
    logic [POS_W-1:0] cs  [NCAND];
    logic [POS_W-1:0] ce  [NCAND];

    assign nxt = (r_pos == MAX_POS) ? r_pos : r_pos + POS_W'(1);

    // A number or keyword ends on the first byte that cannot extend it
    assign tok_ends = ((r_mode == LM_NUM) && !is_digit(i_byte)) ||
                      ((r_mode == LM_KEY) && !is_lower(i_byte));
    assign idle_go  = (r_mode == LM_IDLE) || tok_ends;

    // State after this byte, before any end-of-text flush
    always_comb begin
        mid_mode  = r_mode;
        mid_begin = r_begin;
        case (r_mode)
            LM_STR: begin
                if (i_byte == CH_QUOTE) begin
                    mid_mode = LM_IDLE;
                end else if (i_byte == CH_BSLASH) begin
                    mid_mode = LM_ESC;
                end
            end
            LM_ESC:  mid_mode = LM_STR;
            LM_HALT: mid_mode = LM_HALT;
            default: mid_mode = r_mode;
        endcase
        if (idle_go) begin
            mid_mode = LM_IDLE;
            if (i_byte == CH_QUOTE) begin
                mid_mode  = LM_STR;
                mid_begin = r_pos;
            end else if (is_digit(i_byte)) begin
                mid_mode  = LM_NUM;
                mid_begin = r_pos;
            end else if (is_alpha(i_byte)) begin
                mid_mode  = LM_KEY;
                mid_begin = r_pos;
            end else if (!is_punct(i_byte) && !is_space(i_byte)) begin
                mid_mode = LM_HALT;
            end
        end
    end

    // Next state: return to reset after the final byte of a text
    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_begin = r_begin;
        if (i_fire) begin
            if (i_last) begin
                n_mode  = LM_IDLE;
                n_pos   = '0;
                n_begin = '0;
            end else begin
                n_mode  = mid_mode;
                n_pos   = nxt;
                n_begin = mid_begin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= LM_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
        end
    end

    // Candidate results in emission order
    always_comb begin
        for (int k = 0; k < NCAND; k++) begin
            cv[k]  = 1'b0;
            ck[k]  = KIND_EOF;
            cek[k] = ERR_NONE;
            cs[k]  = nxt;
            ce[k]  = nxt;
        end
        // Token closed or ended by this byte
        if (r_mode == LM_STR && i_byte == CH_QUOTE) begin
            cv[0] = 1'b1;
            ck[0] = KIND_STRING;
            cs[0] = r_begin;
            ce[0] = nxt;
        end else if (tok_ends) begin
            cv[0] = 1'b1;
            ck[0] = (r_mode == LM_NUM) ? KIND_NUMBER : KIND_KEYWORD;
            cs[0] = r_begin;
            ce[0] = r_pos;
        end
        // Punctuation or unknown byte lexed from idle
        if (idle_go && is_punct(i_byte)) begin
            cv[1] = 1'b1;
            ck[1] = punct_kind(i_byte);
            cs[1] = r_pos;
            ce[1] = nxt;
        end else if (idle_go && mid_mode == LM_HALT) begin
            cv[1]  = 1'b1;
            ck[1]  = KIND_ERROR;
            cek[1] = ERR_BYTE;
            cs[1]  = r_pos;
            ce[1]  = nxt;
        end
        // Flush at end of text
        if (i_last && (mid_mode == LM_NUM || mid_mode == LM_KEY)) begin
            cv[2] = 1'b1;
            ck[2] = (mid_mode == LM_NUM) ? KIND_NUMBER : KIND_KEYWORD;
            cs[2] = mid_begin;
        end
        if (i_last && (mid_mode == LM_STR || mid_mode == LM_ESC)) begin
            cv[3]  = 1'b1;
            ck[3]  = KIND_ERROR;
            cek[3] = ERR_UNCLOSED;
            cs[3]  = mid_begin;
            // Drop the string token when a closed token already took a slot
            cv[4]  = !cv[0];
            ck[4]  = KIND_STRING;
            cs[4]  = mid_begin;
        end
        cv[5] = i_last;
    end

    // Pack valid candidates into result slots
    always_comb begin
        logic [RES_CNT_W-1:0] n;
        n = '0;
        for (int j = 0; j < MAX_RES; j++) begin
            o_tag[j]   = '{kind: KIND_EOF, ek: ERR_NONE, last: 1'b0};
            o_start[j] = '0;
            o_end[j]   = '0;
        end
        for (int k = 0; k < NCAND; k++) begin
            if (cv[k] && n != RES_CNT_W'(MAX_RES)) begin
                o_tag[n].kind = ck[k];
                o_tag[n].ek   = cek[k];
                o_start[n]    = cs[k];
                o_end[n]      = ce[k];
                n = n + RES_CNT_W'(1);
            end
        end
        for (int j = 0; j < MAX_RES; j++) begin
            o_tag[j].last = (n != '0) && (RES_CNT_W'(j) == n - RES_CNT_W'(1));
        end
        o_cnt = n;
    end

endmodule

`default_nettype wire

// File: design/jtl_resq.sv
// Result queue: takes up to three results a cycle, hands out one beat a cycle while i_ready is high.
`default_nettype none

module jtl_resq
    import jtl_pkg::*;
#(
    parameter int unsigned POS_W = 17
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [RES_CNT_W-1:0] i_push_n,
    input  wire t_res_tag             i_tag   [MAX_RES],
    input  wire logic [POS_W-1:0]     i_start [MAX_RES],
    input  wire logic [POS_W-1:0]     i_end   [MAX_RES],
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_res_tag                  o_tag,
    output logic [POS_W-1:0]          o_start,
    output logic [POS_W-1:0]          o_end,
    output logic [RQ_CNT_W-1:0]       o_count
);

    t_res_tag            r_tag   [RQ_DEPTH];
    logic [POS_W-1:0]    r_start [RQ_DEPTH];
    logic [POS_W-1:0]    r_end   [RQ_DEPTH];
    logic [RQ_IDX_W-1:0] r_rd, r_wr;
    logic [RQ_CNT_W-1:0] r_cnt;
    logic                pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_tag   = r_tag[r_rd];
    assign o_start = r_start[r_rd];
    assign o_end   = r_end[r_rd];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RES; j++) begin
            if (RES_CNT_W'(j) < i_push_n) begin
                r_tag[r_wr + RQ_IDX_W'(j)]   <= i_tag[j];
                r_start[r_wr + RQ_IDX_W'(j)] <= i_start[j];
                r_end[r_wr + RQ_IDX_W'(j)]   <= i_end[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + RQ_IDX_W'(i_push_n);
            r_rd  <= r_rd + RQ_IDX_W'(pop);
            r_cnt <= r_cnt + RQ_CNT_W'(i_push_n) - RQ_CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// File: design/json_token_lexer_unit.sv
// Top level: JSON token lexer, byte stream in, token stream out.
//
//  channel   dir  payload                                    end marker
//  s_axis    in   tdata[7:0] text byte                       tlast = end of input
//  m_axis    out  tdata start/end offsets, tuser kind/error  tlast = last result of byte
//
// A byte is held in the input register and lexed combinationally; its results
// land in a four-entry queue and leave one beat per cycle while m_axis_tready is high.
// From input beat to first result beat a byte passes the input register, then the queue.
// One byte per cycle is sustained while m_axis_tready is high and each byte causes
// at most one result; a byte with more results occupies the output for one beat each.
// The input register takes a byte whenever the queue holds at most one result.
// Reset is synchronous and clears lexer state, offsets and the queue.
`default_nettype none

module json_token_lexer_unit
    import jtl_pkg::*;
#(
    parameter int unsigned MAX_LEN = LEN_MAX_DEF,
    parameter int unsigned POS_W   = $clog2(MAX_LEN + 1),
    parameter int unsigned DATA_W  = ((2 * POS_W + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // tdata: [7:0] text_byte
    input  wire logic [7:0]        s_axis_tdata,
    input  wire logic              s_axis_tlast,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: [POS_W-1:0] token_start, [2*POS_W-1:POS_W] token_end, zero pad above
    output logic [DATA_W-1:0]      m_axis_tdata,
    // tuser: [3:0] token_kind, [5:4] error_kind
    output logic [5:0]             m_axis_tuser,
    output logic                   m_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic                 fire;
    logic                 room;

    logic [RES_CNT_W-1:0] lx_cnt;
    logic [RES_CNT_W-1:0] push_n;
    t_res_tag             lx_tag   [MAX_RES];
    logic [POS_W-1:0]     lx_start [MAX_RES];
    logic [POS_W-1:0]     lx_end   [MAX_RES];
    t_res_tag             lx_tail;

    t_res_tag             q_tag;
    logic [POS_W-1:0]     q_start, q_end;
    logic [RQ_CNT_W-1:0]  q_count;

    // Lex only when the queue can take the worst case of one byte
    assign room          = (q_count <= RQ_CNT_W'(RQ_DEPTH - MAX_RES));
    assign fire          = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || fire;
    assign push_n        = fire ? lx_cnt : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    jtl_lexer #(
        .MAX_LEN (MAX_LEN),
        .POS_W   (POS_W)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_cnt   (lx_cnt),
        .o_tag   (lx_tag),
        .o_start (lx_start),
        .o_end   (lx_end)
    );

    jtl_resq #(
        .POS_W (POS_W)
    ) u_resq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_tag    (lx_tag),
        .i_start  (lx_start),
        .i_end    (lx_end),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_tag    (q_tag),
        .o_start  (q_start),
        .o_end    (q_end),
        .o_count  (q_count)
    );

    assign m_axis_tdata = DATA_W'({q_end, q_start});
    assign m_axis_tuser = {q_tag.ek, q_tag.kind};
    assign m_axis_tlast = q_tag.last;

    // Final result slot of the current byte
    always_comb begin
        case (lx_cnt)
            RES_CNT_W'(1): lx_tail = lx_tag[0];
            RES_CNT_W'(2): lx_tail = lx_tag[1];
            default:       lx_tail = lx_tag[MAX_RES-1];
        endcase
    end

    a_eof_closes_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_last |-> lx_cnt != '0 && lx_tail.kind == KIND_EOF && lx_tail.last)
        else $error("final byte did not end in an EOF result");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue overfilled");

    a_byte_waits_for_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !room |=> r_in_valid && $stable(r_in_byte))
        else $error("held byte lost while the queue was full");

endmodule

`default_nettype wire
